/* rtl/ssp_pkg.sv */
// Shared types, constants and helpers of the skyline strip packer.
package ssp_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int HEIGHT_BITS_DEF = 16;

    localparam logic [10:0] STRIP_WIDTH_RESET = 11'd1024;
    localparam logic        REG_STRIP_WIDTH   = 1'b0;
    localparam logic [31:0] FIELD16_LIMIT     = 32'h0000_FFFF;
    localparam logic [5:0]  TYPE_TAG_MAX      = 6'd63;
    localparam logic [6:0]  TYPE_COUNT_MAX    = 7'd127;

    typedef struct packed {
        logic [10:0] rect_width;
        logic [15:0] rect_height;
        logic [6:0]  copies;
        logic        last_type;
    } ssp_rect_t;

    typedef struct packed {
        logic [5:0]  item_number;
        logic [5:0]  type_number;
        logic [9:0]  place_x;
        logic [15:0] place_y;
        logic [15:0] strip_height;
        logic        error;
        logic        last_result;
    } ssp_place_t;

    typedef struct packed {
        logic [10:0] w;
        logic [15:0] h;
        logic [5:0]  t;
    } ssp_entry_t;

    function automatic logic [15:0] clamp16(input logic [31:0] v);
        logic [15:0] r;
        r = (v > FIELD16_LIMIT) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

endpackage

/* rtl/ssp_ram.sv */
// Single-port-write, registered-read memory used for the skyline and the item store.
module ssp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ssp_engine.sv */
// Sequencer and shared compare unit that loads items and walks the skyline.
module ssp_engine #(
    parameter int MAX_COLUMNS = ssp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ITEMS   = ssp_pkg::MAX_ITEMS_DEF,
    parameter int HEIGHT_BITS = ssp_pkg::HEIGHT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [10:0]        strip_width,
    input  logic               rect_valid,
    output logic               rect_ready,
    input  ssp_pkg::ssp_rect_t rect,
    output logic               place_valid,
    input  logic               place_ready,
    output ssp_pkg::ssp_place_t place
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int HB = HEIGHT_BITS;
    localparam logic [32:0] HMAX = 33'((64'd1 << HB) - 64'd1);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_LOAD   = 10'b0000000100,
        ST_WIDE   = 10'b0000001000,
        ST_MIN    = 10'b0000010000,
        ST_PICK   = 10'b0000100000,
        ST_RAISE  = 10'b0001000000,
        ST_FILL   = 10'b0010000000,
        ST_PUSH   = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW:0]         col_reg, col_next;
    logic [CW:0]         rem_reg, rem_next;
    logic [CW:0]         sw_reg, sw_next;
    logic [IW:0]         cnt_reg, cnt_next;
    logic [6:0]          tcnt_reg, tcnt_next;
    logic                fault_reg, fault_next;
    logic [MAX_ITEMS-1:0] packed_reg, packed_next;
    logic [HB-1:0]       top_reg, top_next;
    logic [HB-1:0]       minv_reg, minv_next;
    logic [CW-1:0]       start_reg, start_next;
    logic [CW:0]         gap_reg, gap_next;
    logic                inrun_reg, inrun_next;
    logic                hasr_reg, hasr_next;
    logic [HB-1:0]       lv_reg, lv_next;
    logic [HB-1:0]       rv_reg, rv_next;
    logic [HB-1:0]       prev_reg, prev_next;
    logic [IW:0]         sidx_reg, sidx_next;
    logic                rdv_reg, rdv_next;
    logic [CW-1:0]       srda_reg, srda_next;
    logic [IW-1:0]       irda_reg, irda_next;
    ssp_pkg::ssp_entry_t cur_reg, cur_next;
    logic [6:0]          crem_reg, crem_next;
    logic                clast_reg, clast_next;
    logic [IW-1:0]       pidx_reg, pidx_next;
    logic [15:0]         ph_reg, ph_next;
    logic [5:0]          pt_reg, pt_next;
    logic                rerr_reg, rerr_next;
    logic                retw_reg, retw_next;
    ssp_pkg::ssp_place_t res_reg, res_next;
    logic                pendv_reg, pendv_next;
    ssp_pkg::ssp_place_t pend_reg, pend_next;
    logic                outv_reg, outv_next;
    ssp_pkg::ssp_place_t out_reg, out_next;

    logic                sky_we;
    logic [CW-1:0]       sky_waddr, sky_raddr;
    logic [HB-1:0]       sky_wdata, sky_q;
    logic                st_we;
    ssp_pkg::ssp_entry_t st_wdata, st_q;
    logic [IW-1:0]       st_waddr, st_raddr;

    logic [MAX_ITEMS-1:0] full_mask;
    logic                full;
    logic                out_free;
    logic [32:0]         sum;
    logic [HB-1:0]       chosen;
    logic                yerr;
    logic                topovf;
    ssp_pkg::ssp_place_t fin;

    ssp_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(HB)) u_sky (
        .clk(clk), .we(sky_we), .waddr(sky_waddr), .wdata(sky_wdata),
        .raddr(sky_raddr), .rdata(sky_q)
    );

    ssp_ram #(.DEPTH(MAX_ITEMS), .WIDTH($bits(ssp_pkg::ssp_entry_t))) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_q)
    );

    assign rect_ready  = (state_reg == ST_IDLE);
    assign place_valid = outv_reg;
    assign place       = out_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            full_mask[i] = ((IW+1)'(i) < cnt_reg);
        end
        full     = (packed_reg == full_mask);
        out_free = !outv_reg || place_ready;
        sum      = 33'(sky_q) + 33'(ph_reg);
        chosen   = ((start_reg != '0) && (!hasr_reg || lv_reg <= rv_reg)) ? lv_reg : rv_reg;
        yerr     = 32'(minv_reg) > ssp_pkg::FIELD16_LIMIT;
        topovf   = 32'(top_reg) > ssp_pkg::FIELD16_LIMIT;
        fin      = pendv_reg ? pend_reg : '0;
        fin.strip_height = ssp_pkg::clamp16(32'(top_reg));
        fin.error        = fin.error | fault_reg | topovf;
        fin.last_result  = 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        rem_next    = rem_reg;
        sw_next     = sw_reg;
        cnt_next    = cnt_reg;
        tcnt_next   = tcnt_reg;
        fault_next  = fault_reg;
        packed_next = packed_reg;
        top_next    = top_reg;
        minv_next   = minv_reg;
        start_next  = start_reg;
        gap_next    = gap_reg;
        inrun_next  = inrun_reg;
        hasr_next   = hasr_reg;
        lv_next     = lv_reg;
        rv_next     = rv_reg;
        prev_next   = prev_reg;
        sidx_next   = sidx_reg;
        rdv_next    = rdv_reg;
        srda_next   = srda_reg;
        irda_next   = irda_reg;
        cur_next    = cur_reg;
        crem_next   = crem_reg;
        clast_next  = clast_reg;
        pidx_next   = pidx_reg;
        ph_next     = ph_reg;
        pt_next     = pt_reg;
        rerr_next   = rerr_reg;
        retw_next   = retw_reg;
        res_next    = res_reg;
        pendv_next  = pendv_reg;
        pend_next   = pend_reg;
        outv_next   = outv_reg && !place_ready;
        out_next    = out_reg;

        sky_we    = 1'b0;
        sky_waddr = col_reg[CW-1:0];
        sky_wdata = '0;
        sky_raddr = col_reg[CW-1:0];
        st_we     = 1'b0;
        st_waddr  = cnt_reg[IW-1:0];
        st_wdata  = cur_reg;
        st_raddr  = sidx_reg[IW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                sky_we   = 1'b1;
                col_next = col_reg + 1'b1;
                if (col_reg == (CW+1)'(MAX_COLUMNS - 1))
                begin
                    col_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (rect_valid)
                begin
                    cur_next.w = rect.rect_width;
                    cur_next.h = rect.rect_height;
                    cur_next.t = (tcnt_reg > 7'(ssp_pkg::TYPE_TAG_MAX)) ?
                                 ssp_pkg::TYPE_TAG_MAX : tcnt_reg[5:0];
                    crem_next  = rect.copies;
                    clast_next = rect.last_type;
                    if (tcnt_reg != ssp_pkg::TYPE_COUNT_MAX)
                    begin
                        tcnt_next = tcnt_reg + 1'b1;
                    end
                    if (strip_width == '0)
                    begin
                        sw_next = (CW+1)'(1);
                    end
                    else if (32'(strip_width) > 32'(MAX_COLUMNS))
                    begin
                        sw_next = (CW+1)'(MAX_COLUMNS);
                    end
                    else
                    begin
                        sw_next = (CW+1)'(strip_width);
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (crem_reg == '0)
                begin
                    sidx_next  = '0;
                    rdv_next   = 1'b0;
                    state_next = clast_reg ? ST_WIDE : ST_IDLE;
                end
                else if (cnt_reg < (IW+1)'(MAX_ITEMS))
                begin
                    st_we     = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    crem_next = crem_reg - 1'b1;
                end
                else
                begin
                    fault_next = 1'b1;
                    crem_next  = '0;
                end
            end
            ST_WIDE:
            begin
                if (rdv_reg && (32'(st_q.w) > 32'(sw_reg)))
                begin
                    packed_next[irda_reg] = 1'b1;
                    fault_next            = 1'b1;
                    res_next              = '0;
                    res_next.item_number  = 6'(irda_reg);
                    res_next.type_number  = st_q.t;
                    res_next.error        = 1'b1;
                    retw_next             = 1'b1;
                    rdv_next              = 1'b0;
                    sidx_next             = (IW+1)'(irda_reg) + 1'b1;
                    state_next            = ST_PUSH;
                end
                else if (sidx_reg < cnt_reg)
                begin
                    rdv_next  = 1'b1;
                    irda_next = sidx_reg[IW-1:0];
                    sidx_next = sidx_reg + 1'b1;
                end
                else if (!rdv_reg)
                begin
                    col_next   = '0;
                    state_next = full ? ST_FINISH : ST_MIN;
                end
                else
                begin
                    rdv_next = 1'b0;
                end
            end
            ST_MIN:
            begin
                if (rdv_reg)
                begin
                    prev_next = sky_q;
                    if (srda_reg == '0 || sky_q < minv_reg)
                    begin
                        minv_next  = sky_q;
                        start_next = srda_reg;
                        gap_next   = (CW+1)'(1);
                        inrun_next = 1'b1;
                        hasr_next  = 1'b0;
                        lv_next    = prev_reg;
                    end
                    else if (inrun_reg)
                    begin
                        if (sky_q == minv_reg)
                        begin
                            gap_next = gap_reg + 1'b1;
                        end
                        else
                        begin
                            inrun_next = 1'b0;
                            hasr_next  = 1'b1;
                            rv_next    = sky_q;
                        end
                    end
                end
                if (col_reg < sw_reg)
                begin
                    rdv_next  = 1'b1;
                    srda_next = col_reg[CW-1:0];
                    col_next  = col_reg + 1'b1;
                end
                else
                begin
                    rdv_next = 1'b0;
                    if (!rdv_reg)
                    begin
                        sidx_next  = '0;
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK:
            begin
                if (rdv_reg && !packed_reg[irda_reg] && (32'(st_q.w) <= 32'(gap_reg)))
                begin
                    pidx_next  = irda_reg;
                    ph_next    = st_q.h;
                    pt_next    = st_q.t;
                    col_next   = (CW+1)'(start_reg);
                    rem_next   = (CW+1)'(st_q.w);
                    rerr_next  = 1'b0;
                    rdv_next   = 1'b0;
                    state_next = ST_RAISE;
                end
                else if (sidx_reg < cnt_reg)
                begin
                    rdv_next  = 1'b1;
                    irda_next = sidx_reg[IW-1:0];
                    sidx_next = sidx_reg + 1'b1;
                end
                else if (!rdv_reg)
                begin
                    col_next   = (CW+1)'(start_reg);
                    rem_next   = gap_reg;
                    state_next = (start_reg == '0 && !hasr_reg) ? ST_FINISH : ST_FILL;
                end
                else
                begin
                    rdv_next = 1'b0;
                end
            end
            ST_RAISE:
            begin
                sky_waddr = srda_reg;
                if (rdv_reg)
                begin
                    sky_we = 1'b1;
                    if (sum > HMAX)
                    begin
                        sky_wdata = HB'(HMAX);
                        rerr_next = 1'b1;
                    end
                    else
                    begin
                        sky_wdata = HB'(sum);
                    end
                    if (sky_wdata > top_reg)
                    begin
                        top_next = sky_wdata;
                    end
                end
                if (rem_reg != '0)
                begin
                    rdv_next  = 1'b1;
                    srda_next = col_reg[CW-1:0];
                    col_next  = col_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
                else
                begin
                    rdv_next = 1'b0;
                    if (!rdv_reg)
                    begin
                        res_next              = '0;
                        res_next.item_number  = 6'(pidx_reg);
                        res_next.type_number  = pt_reg;
                        res_next.place_x      = 10'(start_reg);
                        res_next.place_y      = ssp_pkg::clamp16(32'(minv_reg));
                        res_next.error        = rerr_reg | yerr;
                        fault_next            = fault_reg | rerr_reg;
                        packed_next[pidx_reg] = 1'b1;
                        retw_next             = 1'b0;
                        state_next            = ST_PUSH;
                    end
                end
            end
            ST_FILL:
            begin
                if (rem_reg != '0)
                begin
                    sky_we    = 1'b1;
                    sky_wdata = chosen;
                    col_next  = col_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
                else
                begin
                    col_next   = '0;
                    rdv_next   = 1'b0;
                    state_next = full ? ST_FINISH : ST_MIN;
                end
            end
            ST_PUSH:
            begin
                if (!pendv_reg || out_free)
                begin
                    if (pendv_reg)
                    begin
                        out_next  = pend_reg;
                        outv_next = 1'b1;
                    end
                    pend_next  = res_reg;
                    pendv_next = 1'b1;
                    col_next   = '0;
                    rdv_next   = 1'b0;
                    if (retw_reg)
                    begin
                        state_next = ST_WIDE;
                    end
                    else
                    begin
                        state_next = full ? ST_FINISH : ST_MIN;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next    = fin;
                    outv_next   = 1'b1;
                    pendv_next  = 1'b0;
                    col_next    = '0;
                    cnt_next    = '0;
                    tcnt_next   = '0;
                    fault_next  = 1'b0;
                    packed_next = '0;
                    top_next    = '0;
                    state_next  = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                col_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            col_reg    <= '0;
            cnt_reg    <= '0;
            tcnt_reg   <= '0;
            fault_reg  <= 1'b0;
            packed_reg <= '0;
            top_reg    <= '0;
            rdv_reg    <= 1'b0;
            pendv_reg  <= 1'b0;
            outv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            cnt_reg    <= cnt_next;
            tcnt_reg   <= tcnt_next;
            fault_reg  <= fault_next;
            packed_reg <= packed_next;
            top_reg    <= top_next;
            rdv_reg    <= rdv_next;
            pendv_reg  <= pendv_next;
            outv_reg   <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        sw_reg    <= sw_next;
        minv_reg  <= minv_next;
        start_reg <= start_next;
        gap_reg   <= gap_next;
        inrun_reg <= inrun_next;
        hasr_reg  <= hasr_next;
        lv_reg    <= lv_next;
        rv_reg    <= rv_next;
        prev_reg  <= prev_next;
        sidx_reg  <= sidx_next;
        srda_reg  <= srda_next;
        irda_reg  <= irda_next;
        cur_reg   <= cur_next;
        crem_reg  <= crem_next;
        clast_reg <= clast_next;
        pidx_reg  <= pidx_next;
        ph_reg    <= ph_next;
        pt_reg    <= pt_next;
        rerr_reg  <= rerr_next;
        retw_reg  <= retw_next;
        res_reg   <= res_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

endmodule

/* rtl/skyline_strip_packer.sv */
// Top level of the skyline strip packer: configuration port and packing engine.
// While a type is loaded into the item store, the block is not ready for another type.
// Each placement is found by a column walk over the skyline memory to find the lowest run
// and a walk over the item store to find the first unplaced item that fits in it.
// A raise to a neighbour follows the same column walk and item-store walk.
// After reset and after every run, a clearing pass zeroes all MAX_COLUMNS skyline entries.
module skyline_strip_packer #(
    parameter int MAX_COLUMNS = ssp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ITEMS   = ssp_pkg::MAX_ITEMS_DEF,
    parameter int HEIGHT_BITS = ssp_pkg::HEIGHT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                rect_valid,
    output logic                rect_ready,
    input  ssp_pkg::ssp_rect_t  rect,
    output logic                place_valid,
    input  logic                place_ready,
    output ssp_pkg::ssp_place_t place
);

    logic [10:0] strip_width_reg, strip_width_next;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ssp_pkg::REG_STRIP_WIDTH) ? 32'(strip_width_reg) : '0;

    always_comb
    begin
        strip_width_next = strip_width_reg;
        if (psel && penable && pwrite && (paddr[2] == ssp_pkg::REG_STRIP_WIDTH))
        begin
            strip_width_next = pwdata[10:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_width_reg <= ssp_pkg::STRIP_WIDTH_RESET;
        end
        else
        begin
            strip_width_reg <= strip_width_next;
        end
    end

    ssp_engine #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ITEMS(MAX_ITEMS),
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .strip_width(strip_width_reg),
        .rect_valid(rect_valid),
        .rect_ready(rect_ready),
        .rect(rect),
        .place_valid(place_valid),
        .place_ready(place_ready),
        .place(place)
    );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the skyline strip packer: directed and random packing runs.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL = 1024;
    localparam int NITEM = 64;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic rect_valid;
    logic rect_ready;
    ssp_pkg::ssp_rect_t rect;
    logic place_valid;
    logic place_ready;
    ssp_pkg::ssp_place_t place;

    skyline_strip_packer dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .rect_valid(rect_valid), .rect_ready(rect_ready), .rect(rect),
        .place_valid(place_valid), .place_ready(place_ready), .place(place)
    );

    int unsigned sky[NCOL];
    logic [10:0] item_w[NITEM];
    logic [15:0] item_h[NITEM];
    logic [5:0] item_t[NITEM];
    logic [NITEM-1:0] placed;
    int unsigned n_items;
    int unsigned n_types;
    bit run_fault;
    logic [10:0] width_reg;
    ssp_pkg::ssp_place_t placements_due[$];
    int errors;
    bit idle_on;
    int stall_cnt;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic ssp_pkg::ssp_place_t make_place(int unsigned it, int unsigned ty,
                                                       int unsigned x, int unsigned y,
                                                       bit err);
        ssp_pkg::ssp_place_t p;
        p = '0;
        if (y > 32'hFFFF)
        begin
            y = 32'hFFFF;
            err = 1'b1;
        end
        p.item_number = it[5:0];
        p.type_number = ty[5:0];
        p.place_x = x[9:0];
        p.place_y = y[15:0];
        p.error = err;
        return p;
    endfunction

    task automatic pack_predict(input ssp_pkg::ssp_rect_t r);
        int unsigned ty, sw, minv, start, gap, col, lv, rv, top, s, n0;
        int pick;
        bit err, has_l, has_r;
        logic [NITEM-1:0] full;
        ssp_pkg::ssp_place_t p;
        ty = (n_types > 63) ? 63 : n_types;
        for (int k = 0; k < r.copies; k++)
        begin
            if (n_items < NITEM)
            begin
                item_w[n_items] = r.rect_width;
                item_h[n_items] = r.rect_height;
                item_t[n_items] = ty[5:0];
                n_items++;
            end
            else
                run_fault = 1'b1;
        end
        if (n_types < 127)
            n_types++;
        if (!r.last_type)
            return;
        sw = width_reg;
        if (sw == 0)
            sw = 1;
        if (sw > NCOL)
            sw = NCOL;
        n0 = placements_due.size();
        for (int i = 0; i < n_items; i++)
        begin
            if (item_w[i] > sw)
            begin
                placed[i] = 1'b1;
                placements_due = {placements_due, make_place(i, item_t[i], 0, 0, 1'b1)};
                run_fault = 1'b1;
            end
        end
        full = (n_items >= NITEM) ? '1 : ((64'd1 << n_items) - 1);
        while (placed != full)
        begin
            minv = sky[0];
            start = 0;
            gap = 0;
            pick = -1;
            for (col = 1; col < sw; col++)
                if (sky[col] < minv)
                begin
                    minv = sky[col];
                    start = col;
                end
            for (col = start; col < sw && sky[col] == minv; col++)
                gap++;
            for (int i = 0; i < n_items; i++)
                if (!placed[i] && item_w[i] <= gap)
                begin
                    pick = i;
                    break;
                end
            if (pick >= 0)
            begin
                err = 1'b0;
                for (col = start; col < start + item_w[pick]; col++)
                begin
                    s = sky[col] + item_h[pick];
                    if (s > 32'hFFFF)
                    begin
                        s = 32'hFFFF;
                        err = 1'b1;
                    end
                    sky[col] = s;
                end
                if (err)
                    run_fault = 1'b1;
                placed[pick] = 1'b1;
                placements_due = {placements_due,
                                  make_place(pick, item_t[pick], start, minv, err)};
            end
            else
            begin
                has_l = start != 0;
                has_r = start + gap < sw;
                lv = has_l ? sky[start-1] : 0;
                rv = has_r ? sky[start+gap] : 0;
                if (!has_l && !has_r)
                    break;
                for (col = start; col < start + gap; col++)
                    sky[col] = (has_l && (!has_r || lv <= rv)) ? lv : rv;
            end
        end
        top = 0;
        for (col = 0; col < sw; col++)
            if (sky[col] > top)
                top = sky[col];
        if (placements_due.size() == n0)
            placements_due = {placements_due, make_place(0, 0, 0, 0, 1'b0)};
        p = placements_due.pop_back();
        p.strip_height = top[15:0];
        p.error = p.error | run_fault;
        p.last_result = 1'b1;
        placements_due = {placements_due, p};
        foreach (sky[c])
            sky[c] = 0;
        placed = '0;
        n_items = 0;
        n_types = 0;
        run_fault = 1'b0;
    endtask

    always @(posedge clk)
    begin
        ssp_pkg::ssp_place_t e;
        if (rst_n && place_valid && place_ready)
        begin
            if (placements_due.size() == 0)
            begin
                errors++;
                $display("%t unexpected placement %p", $time, place);
            end
            else
            begin
                e = placements_due.pop_front();
                if (place !== e)
                begin
                    errors++;
                    $display("%t mismatch expected %p actual %p", $time, e, place);
                end
            end
        end
        if (rst_n)
        begin
            if (stall_cnt != 0)
            begin
                stall_cnt--;
                place_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_cnt = $urandom_range(0, 9);
                place_ready <= 1'b0;
            end
            else
                place_ready <= 1'b1;
        end
    end

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) @(posedge clk);
    endtask

    task automatic send_rect(input logic [10:0] w, input logic [15:0] h,
                             input logic [6:0] c, input bit last);
        ssp_pkg::ssp_rect_t r;
        r.rect_width = w;
        r.rect_height = h;
        r.copies = c;
        r.last_type = last;
        idle_gap();
        rect_valid <= 1'b1;
        rect <= r;
        @(posedge clk);
        while (!rect_ready)
            @(posedge clk);
        pack_predict(r);
        rect_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (placements_due.size() != 0 && guard < 3000000)
        begin
            @(posedge clk);
            guard++;
        end
        if (placements_due.size() != 0)
        begin
            errors++;
            $display("%t missing placement expected %p actual none", $time,
                     placements_due[0]);
            placements_due.delete();
        end
        repeat (1200) @(posedge clk);
    endtask

    task automatic write_strip_width(input logic [10:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {21'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        width_reg = v;
    endtask

    task automatic test_directed();
        send_rect(11'd0, 16'd5, 7'd0, 1'b1);
        send_rect(11'd1024, 16'd1, 7'd1, 1'b0);
        send_rect(11'd2047, 16'd3, 7'd1, 1'b0);
        send_rect(11'd600, 16'hFFFF, 7'd1, 1'b0);
        send_rect(11'd600, 16'hFFFF, 7'd1, 1'b0);
        send_rect(11'd1, 16'd1, 7'd2, 1'b1);
        drain();
        write_strip_width(11'd10);
        send_rect(11'd6, 16'd4, 7'd1, 1'b0);
        send_rect(11'd5, 16'd2, 7'd1, 1'b0);
        send_rect(11'd2, 16'd7, 7'd2, 1'b1);
        send_rect(11'd3, 16'd1, 7'd64, 1'b0);
        send_rect(11'd3, 16'd1, 7'd127, 1'b1);
        drain();
        write_strip_width(11'd0);
        send_rect(11'd1, 16'h8000, 7'd3, 1'b1);
        drain();
        write_strip_width(11'd2047);
        for (int i = 0; i < 70; i++)
            send_rect(11'd1, 16'd1, 7'd0, i == 69);
        drain();
    endtask

    task automatic test_random(input int runs);
        int nt;
        logic [10:0] w;
        logic [10:0] sw;
        for (int r = 0; r < runs; r++)
        begin
            sw = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                           : 11'($urandom_range(1, 64));
            write_strip_width(sw);
            nt = $urandom_range(1, 6);
            w = 11'($urandom_range(1, 64));
            for (int t = 0; t < nt; t++)
            begin
                if ($urandom_range(0, 9) == 0)
                    w = 11'($urandom_range(0, 2047));
                else
                    w = 11'($urandom_range(1, w));
                send_rect(w, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(1, 40)),
                          ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 5)),
                          t == nt - 1);
            end
            drain();
        end
    endtask

    initial
    begin
        errors = 0;
        idle_on = 1'b1;
        stall_cnt = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        rect_valid = 1'b0;
        rect = '0;
        place_ready = 1'b0;
        width_reg = 11'd1024;
        placed = '0;
        n_items = 0;
        n_types = 0;
        run_fault = 1'b0;
        foreach (sky[c])
            sky[c] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (1100) @(posedge clk);
        test_directed();
        test_random(30);
        idle_on = 1'b0;
        test_random(8);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
